>>> hdl/tcpq_pkg.sv
// Package for the two-class priority queue: item structs, codes, default sizes.
// No dependencies; imported by every module of the block.
package tcpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_W           = 8;
  localparam int COUNT_W         = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic {
    CLS_READ  = 1'b0,
    CLS_INPUT = 1'b1
  } cls_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [TAG_W-1:0] query_tag;
    cls_t             query_class;
  } req_item_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] entry_count;
    logic [COUNT_W-1:0] reads_held;
    logic               head_valid;
    logic [TAG_W-1:0]   head_tag;
    cls_t               head_class;
  } rsp_item_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic exec;     // apply it to the cells and load the result register
  } tcpq_cmd_t;

endpackage

>>> hdl/tcpq_ctrl.sv
// Controller FSM for the two-class priority queue: handshakes and sequencing.
// Depends on tcpq_pkg.
module tcpq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output tcpq_pkg::tcpq_cmd_t cmd
);
  import tcpq_pkg::*;

  ctrl_state_t state, state_next;
  logic        rsp_valid_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state)
      S_IDLE: begin
        // result register is free, or is being drained this cycle
        req_ready   = !rsp_valid || rsp_ready;
        cmd.capture = req_valid && req_ready;
      end
      S_EXEC: cmd.exec = 1'b1;
      default: begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_valid && rsp_ready) rsp_valid_next = 1'b0;
    if (cmd.exec) rsp_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

>>> hdl/tcpq_dp.sv
// Datapath for the two-class priority queue: row of tag/class cells with
// parallel match, shift network, counters and result register. Uses tcpq_pkg.
module tcpq_dp #(
  parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tcpq_pkg::tcpq_cmd_t cmd,
  input  tcpq_pkg::req_item_t req,
  output tcpq_pkg::rsp_item_t rsp
);
  import tcpq_pkg::*;

  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL  = $clog2(QUEUE_DEPTH);

  req_item_t q;

  // cells, front at index 0
  logic [TAG_W-1:0] slot_tag   [QUEUE_DEPTH];
  cls_t             slot_class [QUEUE_DEPTH];
  logic [TAG_W-1:0] slot_tag_next   [QUEUE_DEPTH];
  cls_t             slot_class_next [QUEUE_DEPTH];

  logic [CNTW-1:0] fill, fill_next;
  logic [CNTW-1:0] rcnt, rcnt_next;

  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] cls_vec;
  logic [QUEUE_DEPTH-1:0] pre [LVL+1];
  logic [QUEUE_DEPTH-1:0] at_or_after;
  logic [QUEUE_DEPTH-1:0] first_hit;
  logic                   found;
  logic                   hit_read;
  logic [CNTW-1:0]        ins_pos;
  status_t                status;
  logic                   upd;
  rsp_item_t              rsp_next;

  // tag compare in every live cell
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i]   = (slot_tag[i] == q.query_tag) && (CNTW'(i) < fill);
      cls_vec[i] = (slot_class[i] == CLS_INPUT);
    end
  end

  // log-depth prefix OR: bit i set when some match sits at or before cell i
  always_comb begin
    pre[0] = match;
    for (int k = 0; k < LVL; k++) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        pre[k+1][i] = pre[k][i];
        if (i >= (1 << k)) pre[k+1][i] = pre[k][i] | pre[k][i - (1 << k)];
      end
    end
  end

  assign at_or_after = pre[LVL];
  assign first_hit   = at_or_after & ~(at_or_after << 1);
  assign found       = at_or_after[QUEUE_DEPTH-1];
  assign hit_read    = ~|(first_hit & cls_vec);
  assign ins_pos     = (q.query_class == CLS_INPUT) ? fill : rcnt;

  always_comb begin
    status = ST_OK;
    if (q.op == OP_INSERT) begin
      if (fill == CNTW'(QUEUE_DEPTH)) status = ST_FULL;
    end else begin
      if (fill == '0) status = ST_EMPTY;
      else if (!found) status = ST_NOT_FOUND;
    end
  end

  assign upd = (status == ST_OK);

  // shift network: insert opens a gap at ins_pos, remove closes over the hit
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_tag_next[i]   = slot_tag[i];
      slot_class_next[i] = slot_class[i];
      if (upd) begin
        if (q.op == OP_INSERT) begin
          if (CNTW'(i) == ins_pos) begin
            slot_tag_next[i]   = q.query_tag;
            slot_class_next[i] = q.query_class;
          end else if (i > 0 && CNTW'(i) > ins_pos) begin
            slot_tag_next[i]   = slot_tag[i-1];
            slot_class_next[i] = slot_class[i-1];
          end
        end else if (at_or_after[i] && i < QUEUE_DEPTH - 1) begin
          slot_tag_next[i]   = slot_tag[i+1];
          slot_class_next[i] = slot_class[i+1];
        end
      end
    end
  end

  always_comb begin
    fill_next = fill;
    rcnt_next = rcnt;
    if (upd) begin
      if (q.op == OP_INSERT) begin
        fill_next = fill + 1'b1;
        if (q.query_class == CLS_READ) rcnt_next = rcnt + 1'b1;
      end else begin
        fill_next = fill - 1'b1;
        if (hit_read && rcnt != '0) rcnt_next = rcnt - 1'b1;
      end
    end
  end

  always_comb begin
    rsp_next.status      = status;
    rsp_next.entry_count = COUNT_W'(fill_next);
    rsp_next.reads_held  = COUNT_W'(rcnt_next);
    rsp_next.head_valid  = (fill_next != '0);
    rsp_next.head_tag    = rsp_next.head_valid ? slot_tag_next[0] : '0;
    rsp_next.head_class  = rsp_next.head_valid ? slot_class_next[0] : CLS_READ;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) q <= req;
    if (cmd.exec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        slot_tag[i]   <= slot_tag_next[i];
        slot_class[i] <= slot_class_next[i];
      end
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      rcnt <= '0;
    end else if (cmd.exec) begin
      fill <= fill_next;
      rcnt <= rcnt_next;
    end
  end

endmodule

>>> hdl/two_class_priority_queue_top.sv
// Top level of the two-class priority queue: controller plus datapath.
// Depends on tcpq_pkg, tcpq_ctrl and tcpq_dp.
//
// Usage:
//   req channel (req_valid/req_ready/req): one item per insert or remove.
//     Insert places a read-class tag after the last read entry and an
//     input-class tag at the tail. Remove deletes the first matching tag.
//   rsp channel (rsp_valid/rsp_ready/rsp): exactly one item per request,
//     with status, entry and read counts, and the head entry after the step.
//   Sequence: an accepted request is captured in the request register and the
//     controller enters its execute state, then loads the result register and
//     sets rsp_valid; no new request is accepted meanwhile. The cell row does the
//     whole match, shift and count update in the execute cycle.
//   Stall: the result register holds its item until taken; a new request is
//     accepted in the same cycle that the old result is taken.
//   Reset: rst (synchronous) empties the queue, clears rsp_valid and returns
//     the controller to idle. Cell contents are not cleared; cells beyond the
//     fill count are never used, so no clearing pass is needed.
module two_class_priority_queue_top #(
  parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  tcpq_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output tcpq_pkg::rsp_item_t rsp
);
  import tcpq_pkg::*;

  tcpq_cmd_t cmd;

  // sequencing and handshakes
  tcpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  // cells, match logic, counters, result register
  tcpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

  // one request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while another is executing");

  // a fresh result always follows an accepted request, via the execute state
  a_rsp_follows_req: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
    else $error("result appeared without an accepted request");

  // full is only reported for inserts
  a_full_on_insert: assert property (@(posedge clk) disable iff (rst)
    ($rose(rsp_valid) && rsp.status == ST_FULL) |-> $past(req.op == OP_INSERT, 2))
    else $error("full status reported for a remove");

  // empty and not-found are only reported for removes
  a_remove_codes: assert property (@(posedge clk) disable iff (rst)
    ($rose(rsp_valid) && (rsp.status == ST_EMPTY || rsp.status == ST_NOT_FOUND))
      |-> $past(req.op == OP_REMOVE, 2))
    else $error("remove status reported for an insert");

endmodule
